[src/crm_pkg.sv]
// ----------------------------------------------------------------------------
// crm_pkg
// Shared widths, constants and types of the Courant / cell Reynolds unit.
// ----------------------------------------------------------------------------
package crm_pkg;

   localparam int FRAC_BITS = 16;
   localparam int MUL_BITS  = 33;
   localparam int MUL_CNT_W = $clog2(MUL_BITS + 1);
   localparam int QUO_BITS  = 32;
   localparam int DIV_CNT_W = $clog2(QUO_BITS + 1);
   localparam int PROD_W    = 64 + MUL_BITS;

   localparam logic [31:0] TIME_STEP_RESET = 32'(1 << FRAC_BITS);
   localparam logic [31:0] SAT32           = 32'hFFFF_FFFF;

   typedef struct packed {
      logic done;
      logic sat;
   } crm_div_stat_type;

endpackage

[src/crm_mul.sv]
// ----------------------------------------------------------------------------
// crm_mul
// Bit-serial shift-add multiplier with two lanes sharing one multiplier word.
// ----------------------------------------------------------------------------
module crm_mul (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [63:0]                      mcand_a,
   input  logic [63:0]                      mcand_b,
   input  logic [crm_pkg::MUL_BITS-1:0]     mplier,
   output logic                             done,
   output logic [crm_pkg::PROD_W-1:0]       prod_a,
   output logic [crm_pkg::PROD_W-1:0]       prod_b
);

   logic [63:0]                      mca_ff, mcb_ff;
   logic [64:0]                      hia_ff, hib_ff;
   logic [crm_pkg::MUL_BITS-1:0]     loa_ff, lob_ff, mpl_ff;
   logic [crm_pkg::MUL_CNT_W-1:0]    cnt_ff;
   logic                             busy_ff, done_ff;
   logic [64:0]                      suma, sumb;

   always_comb begin
      suma = hia_ff + (mpl_ff[0] ? {1'b0, mca_ff} : 65'd0);
      sumb = hib_ff + (mpl_ff[0] ? {1'b0, mcb_ff} : 65'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= crm_pkg::MUL_CNT_W'(crm_pkg::MUL_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == crm_pkg::MUL_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // The low product bits leave the adder one per cycle into the shift register.
   always_ff @(posedge clock) begin
      if (start) begin
         mca_ff <= mcand_a;
         mcb_ff <= mcand_b;
         mpl_ff <= mplier;
         hia_ff <= '0;
         hib_ff <= '0;
         loa_ff <= '0;
         lob_ff <= '0;
      end else if (busy_ff) begin
         mpl_ff <= mpl_ff >> 1;
         hia_ff <= {1'b0, suma[64:1]};
         hib_ff <= {1'b0, sumb[64:1]};
         loa_ff <= {suma[0], loa_ff[crm_pkg::MUL_BITS-1:1]};
         lob_ff <= {sumb[0], lob_ff[crm_pkg::MUL_BITS-1:1]};
      end
   end

   assign done   = done_ff;
   assign prod_a = {hia_ff[63:0], loa_ff};
   assign prod_b = {hib_ff[63:0], lob_ff};

endmodule

[src/crm_div.sv]
// ----------------------------------------------------------------------------
// crm_div
// Restoring divider, one quotient bit per cycle, saturating at 32 bits.
// ----------------------------------------------------------------------------
module crm_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [63:0]                  num_hi,
   input  logic [31:0]                  num_lo,
   input  logic [63:0]                  den,
   output crm_pkg::crm_div_stat_type    stat,
   output logic [31:0]                  quot
);

   logic [63:0]                     den_ff, rem_ff;
   logic [31:0]                     q_ff;
   logic [crm_pkg::DIV_CNT_W-1:0]   cnt_ff;
   logic                            busy_ff, done_ff, sat_ff;
   logic [64:0]                     trial;
   logic                            fits;

   always_comb begin
      trial = {rem_ff, q_ff[31]};
      fits  = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            // The quotient overflows 32 bits exactly when the upper part already
            // reaches the divisor; a zero divisor falls under the same test.
            if (num_hi >= den) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= crm_pkg::DIV_CNT_W'(crm_pkg::QUO_BITS);
            end
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == crm_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         rem_ff <= num_hi;
         sat_ff <= num_hi >= den;
         q_ff   <= (num_hi >= den) ? crm_pkg::SAT32 : num_lo;
      end else if (busy_ff) begin
         rem_ff <= fits ? 64'(trial - {1'b0, den_ff}) : trial[63:0];
         q_ff   <= {q_ff[30:0], fits};
      end
   end

   assign stat.done = done_ff;
   assign stat.sat  = sat_ff;
   assign quot      = q_ff;

endmodule

[src/courant_reynolds_max_unit.sv]
// ----------------------------------------------------------------------------
// courant_reynolds_max_unit
// Element maximum Courant and cell Reynolds numbers in Q16.16.
// ----------------------------------------------------------------------------
// One item is taken at a time. An item that only accumulates occupies the
// unit for the bit-serial multiply that forms the velocity and length
// products. An item that closes an integration point adds two kinematic
// viscosity divisions, one multiply by the time step and the CFL and Re
// divisions on the shared restoring divider, each division ending early
// when its quotient saturates. A result waits in the output register while
// the next item is already taken.
module courant_reynolds_max_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_vel_left,
   input  logic signed [31:0] req_vel_right,
   input  logic signed [31:0] req_coord_left,
   input  logic signed [31:0] req_coord_right,
   input  logic [31:0]        req_visc_left,
   input  logic [31:0]        req_visc_right,
   input  logic [31:0]        req_rho_left,
   input  logic [31:0]        req_rho_right,
   input  logic               req_last_dim,
   input  logic               req_last_ip,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_elem_cfl,
   output logic [31:0]        rsp_elem_re,
   output logic [31:0]        rsp_max_cfl,
   output logic [31:0]        rsp_max_re,
   output logic               rsp_saturated
);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_MUL_ITEM = 9'b000000010,
      ST_ACCUM    = 9'b000000100,
      ST_DIV_KVL  = 9'b000001000,
      ST_DIV_KVR  = 9'b000010000,
      ST_MUL_STEP = 9'b000100000,
      ST_DIV_CFL  = 9'b001000000,
      ST_DIV_RE   = 9'b010000000,
      ST_EMIT     = 9'b100000000
   } state_type;

   state_type state_ff, state_in, prev_ff;

   logic [32:0] adx_ff, aus_ff;
   logic        neg_ff, last_dim_ff, last_ip_ff;
   logic [31:0] visc_l_ff, visc_r_ff, rho_l_ff, rho_r_ff;
   logic [63:0] dot_ff, dot_in, lsq_ff, lsq_in;
   logic [31:0] kvl_ff, kvl_in, kvr_ff, kvr_in;
   logic [31:0] ecfl_ff, ecfl_in, ere_ff, ere_in, gcfl_ff, gcfl_in, gre_ff, gre_in;
   logic        sat_ff, sat_in;
   logic [31:0] ts_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_ecfl_ff, rsp_ere_ff, rsp_gcfl_ff, rsp_gre_ff;
   logic        rsp_sat_ff;

   logic        accept, entered, emit_go;
   logic [32:0] dx, us;
   logic [63:0] amag, term, lsq;
   logic [64:0] dot_ext, lsq_ext;
   logic [32:0] kv_sum, nu;

   logic                             mul_start, mul_done;
   logic [63:0]                      mul_a, mul_b;
   logic [crm_pkg::MUL_BITS-1:0]     mul_m;
   logic [crm_pkg::PROD_W-1:0]       prod_a, prod_b;
   logic                             div_start;
   logic [63:0]                      div_hi, div_den;
   logic [31:0]                      div_lo, quot;
   crm_pkg::crm_div_stat_type        div_stat;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign entered   = state_ff != prev_ff;
   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      dx      = {req_coord_right[31], req_coord_right} - {req_coord_left[31], req_coord_left};
      us      = {req_vel_left[31], req_vel_left} + {req_vel_right[31], req_vel_right};
      amag    = dot_ff[63] ? 64'(-dot_ff) : dot_ff;
      term    = prod_a[crm_pkg::FRAC_BITS+1 +: 64];
      lsq     = prod_b[crm_pkg::FRAC_BITS +: 64];
      kv_sum  = {1'b0, kvl_ff} + {1'b0, kvr_ff};
      nu      = {1'b0, kv_sum[32:1]} + 33'd1;
   end

   // Operands are taken by the units on the first cycle of their state.
   always_comb begin
      mul_start = entered && ((state_ff == ST_MUL_ITEM) || (state_ff == ST_MUL_STEP));
      if (state_ff == ST_MUL_STEP) begin
         mul_a = amag;
         mul_b = '0;
         mul_m = {1'b0, ts_ff};
      end else begin
         mul_a = {31'b0, aus_ff};
         mul_b = {31'b0, adx_ff};
         mul_m = adx_ff;
      end
      div_start = entered && ((state_ff == ST_DIV_KVL) || (state_ff == ST_DIV_KVR) ||
                              (state_ff == ST_DIV_CFL) || (state_ff == ST_DIV_RE));
      case (state_ff)
         ST_DIV_KVL: begin
            div_hi  = 64'(visc_l_ff >> (32 - crm_pkg::FRAC_BITS));
            div_lo  = visc_l_ff << crm_pkg::FRAC_BITS;
            div_den = {32'b0, rho_l_ff};
         end
         ST_DIV_KVR: begin
            div_hi  = 64'(visc_r_ff >> (32 - crm_pkg::FRAC_BITS));
            div_lo  = visc_r_ff << crm_pkg::FRAC_BITS;
            div_den = {32'b0, rho_r_ff};
         end
         ST_DIV_CFL: begin
            div_hi  = prod_a[95:32];
            div_lo  = prod_a[31:0];
            div_den = lsq_ff;
         end
         default: begin
            div_hi  = amag >> (32 - crm_pkg::FRAC_BITS);
            div_lo  = 32'(amag << crm_pkg::FRAC_BITS);
            div_den = {31'b0, nu};
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      dot_in       = dot_ff;
      lsq_in       = lsq_ff;
      kvl_in       = kvl_ff;
      kvr_in       = kvr_ff;
      ecfl_in      = ecfl_ff;
      ere_in       = ere_ff;
      gcfl_in      = gcfl_ff;
      gre_in       = gre_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      dot_ext      = neg_ff ? {dot_ff[63], dot_ff} - {1'b0, term}
                            : {dot_ff[63], dot_ff} + {1'b0, term};
      lsq_ext      = {1'b0, lsq_ff} + {1'b0, lsq};
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MUL_ITEM;
         end
         ST_MUL_ITEM: begin
            if (mul_done) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            // Signed overflow shows as the two top bits of the sum disagreeing.
            if (dot_ext[64] != dot_ext[63])
               dot_in = dot_ext[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            else
               dot_in = dot_ext[63:0];
            lsq_in = lsq_ext[64] ? '1 : lsq_ext[63:0];
            if (last_dim_ff)      state_in = ST_DIV_KVL;
            else if (last_ip_ff)  state_in = ST_EMIT;
            else                  state_in = ST_IDLE;
         end
         ST_DIV_KVL: begin
            if (div_stat.done) begin
               kvl_in   = quot;
               sat_in   = sat_ff | div_stat.sat;
               state_in = ST_DIV_KVR;
            end
         end
         ST_DIV_KVR: begin
            if (div_stat.done) begin
               kvr_in   = quot;
               sat_in   = sat_ff | div_stat.sat;
               state_in = ST_MUL_STEP;
            end
         end
         ST_MUL_STEP: begin
            if (mul_done) state_in = ST_DIV_CFL;
         end
         ST_DIV_CFL: begin
            if (div_stat.done) begin
               if (quot > ecfl_ff) ecfl_in = quot;
               sat_in   = sat_ff | div_stat.sat;
               state_in = ST_DIV_RE;
            end
         end
         ST_DIV_RE: begin
            if (div_stat.done) begin
               if (quot > ere_ff) ere_in = quot;
               sat_in   = sat_ff | div_stat.sat;
               dot_in   = '0;
               lsq_in   = '0;
               state_in = last_ip_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               if (ecfl_ff > gcfl_ff) gcfl_in = ecfl_ff;
               if (ere_ff > gre_ff)   gre_in  = ere_ff;
               ecfl_in      = '0;
               ere_in       = '0;
               sat_in       = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= ST_IDLE;
         dot_ff       <= '0;
         lsq_ff       <= '0;
         ecfl_ff      <= '0;
         ere_ff       <= '0;
         gcfl_ff      <= '0;
         gre_ff       <= '0;
         sat_ff       <= 1'b0;
         ts_ff        <= crm_pkg::TIME_STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= state_ff;
         dot_ff       <= dot_in;
         lsq_ff       <= lsq_in;
         ecfl_ff      <= ecfl_in;
         ere_ff       <= ere_in;
         gcfl_ff      <= gcfl_in;
         gre_ff       <= gre_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) ts_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      kvl_ff <= kvl_in;
      kvr_ff <= kvr_in;
      if (accept) begin
         adx_ff      <= dx[32] ? 33'(-dx) : dx;
         aus_ff      <= us[32] ? 33'(-us) : us;
         neg_ff      <= dx[32] ^ us[32];
         visc_l_ff   <= req_visc_left;
         visc_r_ff   <= req_visc_right;
         rho_l_ff    <= req_rho_left;
         rho_r_ff    <= req_rho_right;
         last_dim_ff <= req_last_dim;
         last_ip_ff  <= req_last_ip;
      end
      if (emit_go) begin
         rsp_ecfl_ff <= ecfl_ff;
         rsp_ere_ff  <= ere_ff;
         rsp_gcfl_ff <= (ecfl_ff > gcfl_ff) ? ecfl_ff : gcfl_ff;
         rsp_gre_ff  <= (ere_ff > gre_ff) ? ere_ff : gre_ff;
         rsp_sat_ff  <= sat_ff;
      end
   end

   crm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand_a (mul_a),
      .mcand_b (mul_b),
      .mplier  (mul_m),
      .done    (mul_done),
      .prod_a  (prod_a),
      .prod_b  (prod_b)
   );

   crm_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_hi (div_hi),
      .num_lo (div_lo),
      .den    (div_den),
      .stat   (div_stat),
      .quot   (quot)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_elem_cfl  = rsp_ecfl_ff;
   assign rsp_elem_re   = rsp_ere_ff;
   assign rsp_max_cfl   = rsp_gcfl_ff;
   assign rsp_max_re    = rsp_gre_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

[src/crm_checker.sv]
// ----------------------------------------------------------------------------
// crm_checker
// Port-level checks of the Courant / cell Reynolds unit.
// ----------------------------------------------------------------------------
module crm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_elem_cfl,
   input logic [31:0] rsp_elem_re,
   input logic [31:0] rsp_max_cfl,
   input logic [31:0] rsp_max_re
);

   // A stalled result stays valid and holds its CFL values.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_max_cfl) && $stable(rsp_elem_cfl))
      else $error("stalled result changed");

   // The global maxima already include the element being reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_elem_cfl <= rsp_max_cfl) && (rsp_elem_re <= rsp_max_re))
      else $error("element maximum above global maximum");

   // Running maxima never fall between results valid in consecutive cycles.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid || (rsp_max_cfl >= $past(rsp_max_cfl)))
      else $error("global CFL maximum decreased");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid || (rsp_max_re >= $past(rsp_max_re)))
      else $error("global Re maximum decreased");

endmodule

bind courant_reynolds_max_unit crm_checker u_crm_checker (.*);
